### hdl/idwa_pkg.sv
// Shared types, constants and table builders for the inverse distance
// weighted average unit. No dependencies.
package idwa_pkg;

    localparam int DEF_WEIGHT_BITS = 32;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic [15:0] POWER_RESET  = 16'd8192;
    localparam logic [31:0] THRESH_RESET = 32'd1;

    // configuration register indexes
    localparam logic REG_POWER  = 1'b0;
    localparam logic REG_THRESH = 1'b1;

    // item classes decided at the front
    localparam logic [1:0] KIND_SKIP   = 2'd0;
    localparam logic [1:0] KIND_HIT    = 2'd1;
    localparam logic [1:0] KIND_WEIGHT = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic        last;
        logic [31:0] distance;
        logic [31:0] value;
    } idwa_item_t;

    typedef logic [31:0] root_tab_t [16];

    function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] b;
        x   = x_in;
        res = 64'd0;
        b   = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (x >= res + b)
            begin
                x   = x - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // entry i holds 2^(2^-(i+1)) in Q2.30, by repeated square roots from 2.0
    function automatic root_tab_t exp_root_table();
        root_tab_t   tab;
        logic [63:0] r;
        r = 64'd1 << 31;
        for (int i = 0; i < 16; i++)
        begin
            r      = isqrt64(r << 30);
            tab[i] = r[31:0];
        end
        return tab;
    endfunction

endpackage

### hdl/idwa_fifo.sv
// Short item queue between the front and the back of the unit.
// Depends on idwa_pkg.
module idwa_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr,
    input  idwa_pkg::idwa_item_t wr_item,
    output logic                 q_full,
    input  logic                 rd,
    output idwa_pkg::idwa_item_t rd_item,
    output logic                 q_empty
);
    import idwa_pkg::*;

    idwa_item_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;

    assign q_full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign rd_item = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (wr && !rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd && !wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### hdl/idwa_front.sv
// Front part: accepts pairs, tracks hits within a point and classifies each pair.
// Depends on idwa_pkg.
module idwa_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [31:0]          distance,
    input  logic signed [31:0]   sample_value,
    input  logic                 usable,
    input  logic                 last_of_point,
    input  logic [31:0]          hit_threshold,
    input  logic                 q_full,
    output logic                 q_push,
    output idwa_pkg::idwa_item_t q_item
);
    import idwa_pkg::*;

    logic hit_seen_reg;
    logic is_hit;

    assign full   = q_full;
    assign q_push = push && !q_full;
    assign is_hit = distance < hit_threshold;

    always_comb
    begin
        q_item.last     = last_of_point;
        q_item.distance = distance;
        q_item.value    = sample_value;
        if (!usable || hit_seen_reg)
        begin
            q_item.kind = KIND_SKIP;
        end
        else if (is_hit)
        begin
            q_item.kind = KIND_HIT;
        end
        else
        begin
            q_item.kind = KIND_WEIGHT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_seen_reg <= 1'b0;
        end
        else if (q_push)
        begin
            // drop later pairs of a point once it has a hit
            if (last_of_point)
            begin
                hit_seen_reg <= 1'b0;
            end
            else if (q_item.kind == KIND_HIT)
            begin
                hit_seen_reg <= 1'b1;
            end
        end
    end

endmodule

### hdl/idwa_back.sv
// Back part: weight by iterative log2/exp2, saturating accumulation,
// serial division and the result register. Depends on idwa_pkg.
module idwa_back #(
    parameter int WEIGHT_BITS = idwa_pkg::DEF_WEIGHT_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [15:0]          power,
    input  logic                 q_empty,
    input  idwa_pkg::idwa_item_t q_item,
    output logic                 q_pop,
    output logic                 empty,
    input  logic                 pop,
    output logic signed [31:0]   interpolated,
    output logic                 no_weight
);
    import idwa_pkg::*;

    localparam int WFRAC = WEIGHT_BITS / 2;
    localparam logic [WEIGHT_BITS-1:0] WMAX = '1;
    localparam logic [63:0] WMAX64 = (64'd1 << WEIGHT_BITS) - 64'd1;
    localparam logic signed [11:0] SH_OFS = 12'(WFRAC - 30);
    localparam logic signed [11:0] SAT_SH = 12'(WEIGHT_BITS - 30);
    localparam root_tab_t EXP_ROOT = exp_root_table();

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_NORM   = 4'd1;
    localparam logic [3:0] ST_LOG    = 4'd2;
    localparam logic [3:0] ST_TMUL   = 4'd3;
    localparam logic [3:0] ST_TSPLIT = 4'd4;
    localparam logic [3:0] ST_EXP    = 4'd5;
    localparam logic [3:0] ST_SHIFT  = 4'd6;
    localparam logic [3:0] ST_PA     = 4'd7;
    localparam logic [3:0] ST_PB     = 4'd8;
    localparam logic [3:0] ST_PC     = 4'd9;
    localparam logic [3:0] ST_PD     = 4'd10;
    localparam logic [3:0] ST_FIN    = 4'd11;
    localparam logic [3:0] ST_DIV    = 4'd12;
    localparam logic [3:0] ST_DEND   = 4'd13;
    localparam logic [3:0] ST_OUT    = 4'd14;

    logic [3:0]             state_reg;
    logic [5:0]             cnt_reg;
    logic                   last_reg;
    logic [31:0]            x_reg;
    logic [4:0]             k_reg;
    logic [15:0]            frac_reg;
    logic [24:0]            t_reg;
    logic                   eneg_reg;
    logic [15:0]            fr_reg;
    logic signed [10:0]     ip_reg;
    logic [31:0]            m_reg;
    logic [WEIGHT_BITS-1:0] w_reg;
    logic [31:0]            mag_reg;
    logic                   neg_reg;
    logic [55:0]            pl_reg;
    logic [55:0]            ph_reg;
    logic [63:0]            p_reg;
    logic signed [63:0]     wsum_reg;
    logic [63:0]            wtsum_reg;
    logic                   hit_seen_reg;
    logic [31:0]            hit_val_reg;
    logic [63:0]            rem_reg;
    logic [63:0]            quo_reg;
    logic [31:0]            res_reg;
    logic                   res_nw_reg;
    logic                   out_valid_reg;
    logic [31:0]            out_val_reg;
    logic                   out_nw_reg;

    logic [63:0]            sq;
    logic [63:0]            mp;
    logic [63:0]            mp_rnd;
    logic signed [21:0]     lsig;
    logic [20:0]            lmag;
    logic [36:0]            tprod;
    logic [8:0]             tint;
    logic signed [11:0]     sh;
    logic signed [11:0]     nsh;
    logic [63:0]            wide;
    logic [WEIGHT_BITS-1:0] w_calc;
    logic [47:0]            w48;
    logic [79:0]            prod;
    logic [64:0]            acc_sum;
    logic [64:0]            wt_sum;
    logic [64:0]            rem_sh;
    logic [63:0]            um;
    logic [31:0]            q_clamp;
    logic                   out_free;
    logic                   load_out;

    assign q_pop        = (state_reg == ST_IDLE) && !q_empty;
    assign empty        = !out_valid_reg;
    assign interpolated = out_val_reg;
    assign no_weight    = out_nw_reg;
    assign out_free     = !out_valid_reg || pop;
    assign load_out     = (state_reg == ST_OUT) && out_free;

    assign sq     = 64'(x_reg) * 64'(x_reg);
    assign mp     = 64'(m_reg) * 64'(EXP_ROOT[cnt_reg[3:0]]);
    assign mp_rnd = mp + (64'd1 << 29);
    assign lsig   = {6'(k_reg) - 6'd16, frac_reg};
    assign lmag   = lsig[21] ? 21'(-lsig) : lsig[20:0];
    assign tprod  = 37'(power) * 37'(lmag) + 37'd2048;
    assign tint   = t_reg[24:16];
    assign sh     = $signed({ip_reg[10], ip_reg}) + SH_OFS;
    assign nsh    = -sh;
    assign w48    = 48'(w_reg);
    assign prod   = ({24'd0, ph_reg} << 24) + 80'(pl_reg);
    assign acc_sum = {wsum_reg[63], wsum_reg} + {p_reg[63], p_reg};
    assign wt_sum  = {1'b0, wtsum_reg} + 65'(w_reg);
    assign rem_sh  = {rem_reg, quo_reg[63]};
    assign um      = wsum_reg[63] ? (64'd0 - wsum_reg) : wsum_reg;

    // 2^E scaled to the weight format
    always_comb
    begin
        wide   = 64'd0;
        w_calc = '0;
        if (sh >= 12'sd0)
        begin
            if (sh >= SAT_SH)
            begin
                w_calc = WMAX;
            end
            else
            begin
                wide   = {32'd0, m_reg} << sh[5:0];
                w_calc = (wide > WMAX64) ? WMAX : wide[WEIGHT_BITS-1:0];
            end
        end
        else if (nsh <= 12'sd32)
        begin
            wide   = ({32'd0, m_reg} + (64'd1 << (nsh[5:0] - 6'd1))) >> nsh[5:0];
            w_calc = (wide > WMAX64) ? WMAX : wide[WEIGHT_BITS-1:0];
        end
    end

    always_comb
    begin
        if (wsum_reg[63])
        begin
            q_clamp = (quo_reg > 64'h8000_0000) ? 32'h8000_0000 : quo_reg[31:0];
            q_clamp = 32'd0 - q_clamp;
        end
        else
        begin
            q_clamp = (quo_reg > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo_reg[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            last_reg      <= 1'b0;
            x_reg         <= '0;
            k_reg         <= '0;
            frac_reg      <= '0;
            t_reg         <= '0;
            eneg_reg      <= 1'b0;
            fr_reg        <= '0;
            ip_reg        <= '0;
            m_reg         <= '0;
            w_reg         <= '0;
            mag_reg       <= '0;
            neg_reg       <= 1'b0;
            pl_reg        <= '0;
            ph_reg        <= '0;
            p_reg         <= '0;
            wsum_reg      <= '0;
            wtsum_reg     <= '0;
            hit_seen_reg  <= 1'b0;
            hit_val_reg   <= '0;
            rem_reg       <= '0;
            quo_reg       <= '0;
            res_reg       <= '0;
            res_nw_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_val_reg   <= '0;
            out_nw_reg    <= 1'b0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        last_reg <= q_item.last;
                        neg_reg  <= q_item.value[31];
                        mag_reg  <= q_item.value[31] ? (~q_item.value + 32'd1)
                                                      : q_item.value;
                        x_reg    <= q_item.distance;
                        k_reg    <= 5'd31;
                        if (q_item.kind == KIND_WEIGHT)
                        begin
                            if (q_item.distance == 32'd0)
                            begin
                                w_reg     <= (power == 16'd0) ?
                                             (WEIGHT_BITS'(1) << WFRAC) : WMAX;
                                state_reg <= ST_PA;
                            end
                            else
                            begin
                                state_reg <= ST_NORM;
                            end
                        end
                        else
                        begin
                            if (q_item.kind == KIND_HIT)
                            begin
                                hit_seen_reg <= 1'b1;
                                hit_val_reg  <= q_item.value;
                            end
                            state_reg <= ST_FIN;
                        end
                    end
                end
                ST_NORM:
                begin
                    if (x_reg[31])
                    begin
                        cnt_reg   <= '0;
                        frac_reg  <= '0;
                        state_reg <= ST_LOG;
                    end
                    else
                    begin
                        x_reg <= x_reg << 1;
                        k_reg <= k_reg - 5'd1;
                    end
                end
                ST_LOG:
                begin
                    // one fraction bit of log2 per squaring
                    frac_reg <= {frac_reg[14:0], sq[63]};
                    x_reg    <= sq[63] ? sq[63:32] : sq[62:31];
                    cnt_reg  <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd15)
                    begin
                        state_reg <= ST_TMUL;
                    end
                end
                ST_TMUL:
                begin
                    eneg_reg  <= !lsig[21] && (lsig != 22'sd0);
                    t_reg     <= tprod[36:12];
                    state_reg <= ST_TSPLIT;
                end
                ST_TSPLIT:
                begin
                    if (!eneg_reg)
                    begin
                        ip_reg <= $signed({2'b00, tint});
                        fr_reg <= t_reg[15:0];
                    end
                    else if (t_reg[15:0] == 16'd0)
                    begin
                        ip_reg <= -$signed({2'b00, tint});
                        fr_reg <= 16'd0;
                    end
                    else
                    begin
                        ip_reg <= -$signed({2'b00, tint}) - 11'sd1;
                        fr_reg <= 16'd0 - t_reg[15:0];
                    end
                    m_reg     <= 32'd1 << 30;
                    cnt_reg   <= '0;
                    state_reg <= ST_EXP;
                end
                ST_EXP:
                begin
                    if (fr_reg[4'd15 - cnt_reg[3:0]])
                    begin
                        m_reg <= mp_rnd[61:30];
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd15)
                    begin
                        state_reg <= ST_SHIFT;
                    end
                end
                ST_SHIFT:
                begin
                    w_reg     <= w_calc;
                    state_reg <= ST_PA;
                end
                ST_PA:
                begin
                    pl_reg    <= 56'(mag_reg) * 56'(w48[23:0]);
                    state_reg <= ST_PB;
                end
                ST_PB:
                begin
                    ph_reg    <= 56'(mag_reg) * 56'(w48[47:24]);
                    state_reg <= ST_PC;
                end
                ST_PC:
                begin
                    if (prod[79:63] != '0)
                    begin
                        p_reg <= neg_reg ? 64'h8000_0000_0000_0000
                                         : 64'h7FFF_FFFF_FFFF_FFFF;
                    end
                    else
                    begin
                        p_reg <= neg_reg ? (64'd0 - prod[63:0]) : prod[63:0];
                    end
                    state_reg <= ST_PD;
                end
                ST_PD:
                begin
                    if (acc_sum[64] != acc_sum[63])
                    begin
                        wsum_reg <= acc_sum[64] ? 64'sh8000_0000_0000_0000
                                                : 64'sh7FFF_FFFF_FFFF_FFFF;
                    end
                    else
                    begin
                        wsum_reg <= acc_sum[63:0];
                    end
                    wtsum_reg <= wt_sum[64] ? '1 : wt_sum[63:0];
                    state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    if (!last_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (hit_seen_reg)
                    begin
                        res_reg    <= hit_val_reg;
                        res_nw_reg <= 1'b0;
                        state_reg  <= ST_OUT;
                    end
                    else if (wtsum_reg == 64'd0)
                    begin
                        res_reg    <= '0;
                        res_nw_reg <= 1'b1;
                        state_reg  <= ST_OUT;
                    end
                    else
                    begin
                        rem_reg   <= '0;
                        quo_reg   <= um;
                        cnt_reg   <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    // restoring division, one quotient bit per cycle
                    if (rem_sh >= {1'b0, wtsum_reg})
                    begin
                        rem_reg <= 64'(rem_sh - {1'b0, wtsum_reg});
                        quo_reg <= {quo_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh[63:0];
                        quo_reg <= {quo_reg[62:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63)
                    begin
                        state_reg <= ST_DEND;
                    end
                end
                ST_DEND:
                begin
                    res_reg    <= q_clamp;
                    res_nw_reg <= 1'b0;
                    state_reg  <= ST_OUT;
                end
                ST_OUT:
                begin
                    // hold until the result slot is free
                    if (out_free)
                    begin
                        out_val_reg   <= res_reg;
                        out_nw_reg    <= res_nw_reg;
                        wsum_reg      <= '0;
                        wtsum_reg     <= '0;
                        hit_seen_reg  <= 1'b0;
                        hit_val_reg   <= '0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### hdl/inverse_distance_weighted_average_unit.sv
// Top level of the inverse distance weighted average unit: configuration
// registers, front, item queue and back. Depends on idwa_pkg and all idwa_ modules.
//
//   channel   | handshake            | payload
//   ----------+----------------------+---------------------------------------------
//   input     | push / full          | distance, sample_value, usable, last_of_point
//   result    | pop / empty          | interpolated, no_weight
//   config    | wr_en                | wr_index, wr_data
//
// A weighted pair passes through normalization, 16 log2 squarings and 16 exp2 steps,
// plus pop, exponent split, multiply, accumulate and finish; the iterative log2 and
// exp2 loops dominate its processing. A hit or skipped pair only needs pop and finish.
// A point's last pair also loads the result, after the serial divider when it runs.
// The front keeps accepting into a 4-entry queue while the back works.
// Reset sets power to 2.0 and hit_threshold to one LSB and clears all sums.
// A held result in the output register stalls the back; the front stalls once the queue is full.
module inverse_distance_weighted_average_unit #(
    parameter int WEIGHT_BITS = idwa_pkg::DEF_WEIGHT_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [31:0]         distance,
    input  logic signed [31:0]  sample_value,
    input  logic                usable,
    input  logic                last_of_point,
    output logic                empty,
    input  logic                pop,
    output logic signed [31:0]  interpolated,
    output logic                no_weight,
    input  logic                wr_en,
    input  logic                wr_index,
    input  logic [31:0]         wr_data
);
    import idwa_pkg::*;

    logic [15:0] power_reg;
    logic [31:0] thresh_reg;
    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_empty;
    idwa_item_t  push_item;
    idwa_item_t  pop_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_reg  <= POWER_RESET;
            thresh_reg <= THRESH_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_POWER:  power_reg  <= wr_data[15:0];
                REG_THRESH: thresh_reg <= wr_data;
                default:    power_reg  <= power_reg;
            endcase
        end
    end

    idwa_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .distance      (distance),
        .sample_value  (sample_value),
        .usable        (usable),
        .last_of_point (last_of_point),
        .hit_threshold (thresh_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (push_item)
    );

    idwa_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_push),
        .wr_item (push_item),
        .q_full  (q_full),
        .rd      (q_pop),
        .rd_item (pop_item),
        .q_empty (q_empty)
    );

    idwa_back #(
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .power        (power_reg),
        .q_empty      (q_empty),
        .q_item       (pop_item),
        .q_pop        (q_pop),
        .empty        (empty),
        .pop          (pop),
        .interpolated (interpolated),
        .no_weight    (no_weight)
    );

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("item written into a full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("item read from an empty queue");

    a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_full && q_empty))
        else $error("queue both full and empty");

endmodule
